FILE: hw/rtl/gtr_pkg.sv
// Shared types, register indexes and font table of the 6x8 glyph text renderer.
package gtr_pkg;

	localparam int CHAR_COUNT_DEF = 256;
	localparam int MAX_PIXELS     = 60;
	localparam int FONT_WORDS     = 384;
	localparam int FONT_HALF      = 192;

	localparam logic [7:0] TAB_CODE     = 8'd9;
	localparam logic [4:0] CELL_COLS    = 5'd6;
	localparam logic [4:0] TAB_COLS     = 5'd18;
	localparam logic [17:0] CELL_ADV    = 18'd6;
	localparam logic [17:0] TAB_ADV     = 18'd18;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR  = 3'd5;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [15:0] ROW_PITCH_RST    = 16'd2560;
	localparam logic [31:0] FRAME_BASE_RST   = 32'd0;
	localparam logic [31:0] FORE_COLOUR_RST  = 32'hFFFF_FFFF;
	localparam logic [31:0] BACK_COLOUR_RST  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0]         char_code;
		logic               start_text;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
	} char_item_t;

	typedef struct packed {
		logic [31:0] pixel_addr;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [31:0] pixel_colour;
		logic        last_pixel;
	} pixel_item_t;

	localparam logic [31:0] FONT_LO [FONT_HALF] = '{
		32'h00000000, 32'h3E000000, 32'h3E455145, 32'h6F6B3E00, 32'h1C003E6B,
		32'h1C3E7C3E, 32'h7E3C1800, 32'h3000183C, 32'h30367F36, 32'h7E5C1800,
		32'h0000185C, 32'h00001818, 32'hE7E7FFFF, 32'h0000FFFF, 32'h00000000,
		32'hDBDBC3FF, 32'h3000FFC3, 32'h0E364A48, 32'h79290600, 32'h60000629,
		32'h04023F70, 32'h0A7E6000, 32'h2A003F35, 32'h2A1C361C, 32'h3E7F0000,
		32'h0800081C, 32'h007F3E1C, 32'h7F361400, 32'h00001436, 32'h005F005F,
		32'h7F090600, 32'h22007F01, 32'h2259554D, 32'h60606000, 32'h14000060,
		32'h14B6FFB6, 32'h7F060400, 32'h10000406, 32'h10307F30, 32'h3E080800,
		32'h0800081C, 32'h08083E1C, 32'h40407800, 32'h08004040, 32'h083E083E,
		32'h3F3C3000, 32'h0300303C, 32'h030F3F0F, 32'h00000000, 32'h00000000,
		32'h00065F06, 32'h00030700, 32'h24000307, 32'h247E247E, 32'h6A2B2400,
		32'h63000012, 32'h63640813, 32'h56493600, 32'h00005020, 32'h00000307,
		32'h413E0000, 32'h00000000, 32'h00003E41, 32'h1C3E0800, 32'h0800083E,
		32'h08083E08, 32'h60E00000, 32'h08000000, 32'h08080808, 32'h60600000,
		32'h20000000, 32'h02040810, 32'h49513E00, 32'h00003E45, 32'h00407F42,
		32'h49516200, 32'h22004649, 32'h36494949, 32'h12141800, 32'h2F00107F,
		32'h31494949, 32'h494A3C00, 32'h01003049, 32'h03050971, 32'h49493600,
		32'h06003649, 32'h1E294949, 32'h6C6C0000, 32'h00000000, 32'h00006CEC,
		32'h22140800, 32'h24000041, 32'h24242424, 32'h22410000, 32'h02000814,
		32'h06095901, 32'h5D413E00, 32'h7E001E55, 32'h7E111111, 32'h49497F00,
		32'h3E003649, 32'h22414141, 32'h41417F00, 32'h7F003E41, 32'h41494949,
		32'h09097F00, 32'h3E000109, 32'h7A494941, 32'h08087F00, 32'h00007F08,
		32'h00417F41, 32'h40403000, 32'h7F003F40, 32'h41221408, 32'h40407F00,
		32'h7F004040, 32'h7F020402, 32'h04027F00, 32'h3E007F08, 32'h3E414141,
		32'h09097F00, 32'h3E000609, 32'h5E215141, 32'h09097F00, 32'h26006619,
		32'h32494949, 32'h7F010100, 32'h3F000101, 32'h3F404040, 32'h40201F00,
		32'h3F001F20, 32'h3F403C40, 32'h08146300, 32'h07006314, 32'h07087008,
		32'h45497100, 32'h00000043, 32'h0041417F, 32'h08040200, 32'h00002010,
		32'h007F4141, 32'h01020400, 32'h80800402, 32'h80808080, 32'h07030000,
		32'h20000000, 32'h78545454, 32'h44447F00, 32'h38003844, 32'h28444444,
		32'h44443800, 32'h38007F44, 32'h08545454, 32'h097E0800, 32'h18000009,
		32'h7CA4A4A4, 32'h04047F00, 32'h00000078, 32'h00407D00, 32'h84804000,
		32'h7F00007D, 32'h00442810, 32'h7F000000, 32'h7C000040, 32'h78041804,
		32'h04047C00, 32'h38000078, 32'h38444444, 32'h4444FC00, 32'h38003844,
		32'hFC444444, 32'h44784400, 32'h08000804, 32'h20545454, 32'h443E0400,
		32'h3C000024, 32'h007C2040, 32'h40201C00, 32'h3C001C20, 32'h3C603060,
		32'h10106C00, 32'h9C00006C, 32'h003C60A0, 32'h54546400, 32'h0800004C,
		32'h0041413E, 32'h77000000, 32'h00000000, 32'h083E4141, 32'h02010200,
		32'h3C000001, 32'h3C262326
	};

	localparam logic [31:0] FONT_HI [FONT_HALF] = '{
		32'hE1A11E00, 32'h3D001221, 32'h007D2040,
		32'h54543800, 32'h20000955, 32'h78555555, 32'h54552000, 32'h20007855,
		32'h78545555, 32'h55572000, 32'h1C007857, 32'h1422E2A2, 32'h55553800,
		32'h38000855, 32'h08555455, 32'h55553800, 32'h00000854, 32'h00417C01,
		32'h79020000, 32'h00000042, 32'h00407C01, 32'h24297000, 32'h78007029,
		32'h782F252F, 32'h54547C00, 32'h34004555, 32'h58547C54, 32'h7F097E00,
		32'h38004949, 32'h00394545, 32'h44453800, 32'h39000039, 32'h00384445,
		32'h21413C00, 32'h3D00007D, 32'h007C2041, 32'h60A19C00, 32'h3D00003D,
		32'h003D4242, 32'h40413C00, 32'h1800003D, 32'h00246624, 32'h493E4800,
		32'h29006249, 32'h292A7C2A, 32'h16097F00, 32'h40001078, 32'h02097E88,
		32'h55542000, 32'h00007855, 32'h00417D00, 32'h45443800, 32'h3C000039,
		32'h007D2140, 32'h0A097A00, 32'h7A000071, 32'h00792211, 32'h55550800,
		32'h4E005E55, 32'h004E5151, 32'h4D483000, 32'h3C002040, 32'h04040404,
		32'h04040404, 32'h17001C04, 32'h506A4C08, 32'h34081700, 32'h0000782A,
		32'h00307D30, 32'h00140800, 32'h14001408, 32'h08140008, 32'h11441144,
		32'h55AA1144, 32'h55AA55AA, 32'hEEBBEEBB, 32'h0000EEBB, 32'h0000FF00,
		32'hFF080808, 32'h0A0A0000, 32'h0000FF0A, 32'hFF00FF08, 32'hF8080000,
		32'h0000F808, 32'hFE0A0A0A, 32'hFB0A0000, 32'h0000FF00, 32'hFF00FF00,
		32'hFA0A0000, 32'h0000FE02, 32'h0F080B0A, 32'h0F080000, 32'h00000F08,
		32'h0F0A0A0A, 32'h08080000, 32'h0000F808, 32'h0F000000, 32'h08080808,
		32'h08080F08, 32'hF8080808, 32'h00000808, 32'h0808FF00, 32'h08080808,
		32'h08080808, 32'h0808FF08, 32'hFF000000, 32'hFF000A0A, 32'h0808FF00,
		32'h0B080F00, 32'hFE000A0A, 32'h0A0AFA02, 32'h0B080B0A, 32'hFA0A0A0A,
		32'h0A0AFA02, 32'hFB00FF00, 32'h0A0A0A0A, 32'h0A0A0A0A, 32'hFB00FB0A,
		32'h0A0A0A0A, 32'h0A0A0B0A, 32'h0F080F08, 32'h0A0A0808, 32'h0A0AFA0A,
		32'hF808F808, 32'h0F000808, 32'h08080F08, 32'h0F000000, 32'h00000A0A,
		32'h0A0AFE00, 32'hF808F800, 32'hFF080808, 32'h0808FF00, 32'hFB0A0A0A,
		32'h08080A0A, 32'h00000F08, 32'hF8000000, 32'hFFFF0808, 32'hFFFFFFFF,
		32'hF0F0F0F0, 32'hFFFFF0F0, 32'h000000FF, 32'hFF000000, 32'h0F0FFFFF,
		32'h0F0F0F0F, 32'h24241800, 32'hFE002418, 32'h00344A4A, 32'h01017F00,
		32'h02000003, 32'h027E027E, 32'h49556300, 32'h18000063, 32'h041C2424,
		32'h2020FC00, 32'h0800001C, 32'h00047804, 32'h77550800, 32'h3E000855,
		32'h003E4949, 32'h02724C00, 32'h22004C72, 32'h00305955, 32'h18241800,
		32'h18001824, 32'h18247E24, 32'h2A2A1C00, 32'h3C00002A, 32'h003C0202,
		32'h2A2A2A00, 32'h0000002A, 32'h00242E24, 32'h4A4A5100, 32'h44000044,
		32'h00514A4A, 32'hFC000000, 32'h20000402, 32'h00003F40, 32'h2A080800,
		32'h24000808, 32'h00122412, 32'h09090600, 32'h00000006, 32'h00001818,
		32'h00080000, 32'h30000000, 32'h02023E40, 32'h010E0100, 32'h0900000E,
		32'h00000A0D, 32'h3C3C3C00, 32'h0000003C, 32'h00000000
	};

	// font byte k: byte k[1:0] of word k[10:2]
	function automatic logic [7:0] font_byte(input logic [10:0] k);
		logic [8:0]  w;
		logic [31:0] word;
		begin
			w = k[10:2];
			if (w < 9'(FONT_HALF)) begin
				word = FONT_LO[w[7:0]];
			end else begin
				word = FONT_HI[8'(w - 9'(FONT_HALF))];
			end
			font_byte = word[{k[1:0], 3'b000} +: 8];
		end
	endfunction

endpackage

FILE: hw/rtl/gtr_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
interface gtr_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hw/rtl/glyph_text_renderer_6x8_core.sv
// Top level of the 6x8 glyph text renderer: sequencer, cursor state and pixel output.
//
// One character item is taken when the block is idle. Loading the glyph fetches one font
// byte per cycle in the setup state (the row start address is formed by the single
// multiplier in the same window), then the scan walks the cell one position per cycle
// while the pixel sink does not stall, row by row: 48 positions for an ordinary code,
// 144 for a tab with an opaque background (the scan stops at the 60th pixel), then the
// flush state releases the last pixel. The last emitted pixel sits in the output
// register while the next item loads.
module glyph_text_renderer_6x8_core
	import gtr_pkg::*;
#(
	parameter int CHAR_COUNT = CHAR_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	gtr_stream_if.sink           char_in,
	gtr_stream_if.source         pixel_out
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]  state_q;
	logic [2:0]  step_q;

	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic [15:0]        pitch_q;
	logic [31:0]        base_q;
	logic [31:0]        fore_q;
	logic signed [31:0] back_q;

	logic [17:0]        cursor_q;
	logic signed [15:0] row_q;

	logic [7:0]         code_q;
	logic               tab_q;
	logic [10:0]        k_q;
	logic [47:0]        glyph_q;
	logic [17:0]        cx_q;
	logic signed [15:0] ty_q;
	logic [31:0]        prod_q;
	logic [31:0]        row_addr_q;
	logic [2:0]         r_q;
	logic [4:0]         i_q;
	logic [5:0]         n_q;

	logic        pend_v_q;
	pixel_item_t pend_q;
	logic        out_v_q;
	pixel_item_t out_q;

	char_item_t         in_item;
	logic               in_fire;
	logic [17:0]        cx_new;
	logic signed [15:0] ty_new;
	logic signed [32:0] prod_full;
	logic               opaque;
	logic [4:0]         last_col;
	logic [16:0]        py;
	logic [18:0]        px;
	logic               vis;
	logic               bit_set;
	logic               emit;
	logic               out_free;
	logic               stall;
	logic               scan_end;
	logic               glyph_ok;
	logic               out_load;
	pixel_item_t        cand;
	pixel_item_t        pend_last;

	assign in_item       = char_in.payload;
	assign char_in.ready = (state_q == ST_IDLE);
	assign in_fire       = char_in.valid && char_in.ready;

	assign pixel_out.valid   = out_v_q;
	assign pixel_out.payload = out_q;

	assign cx_new = in_item.start_text ? {{2{in_item.origin_x[15]}}, in_item.origin_x} : cursor_q;
	assign ty_new = in_item.start_text ? in_item.origin_y : row_q;

	assign prod_full = $signed({1'b0, pitch_q}) * ty_q;
	assign glyph_ok  = ({1'b0, code_q} < 9'(CHAR_COUNT));

	assign opaque   = !back_q[31];
	assign last_col = (tab_q && opaque) ? TAB_COLS - 5'd1 : CELL_COLS - 5'd1;
	assign py       = {ty_q[15], ty_q} + {14'd0, r_q};
	assign px       = {cx_q[17], cx_q} + {14'd0, i_q};
	assign vis      = !py[16] && (py < {4'd0, height_q}) &&
	                  !px[18] && (px[17:0] < {5'd0, width_q});
	assign bit_set  = (i_q < CELL_COLS) ? glyph_q[{i_q[2:0], r_q}] : 1'b0;
	assign emit     = vis && (bit_set || opaque);
	assign out_free = !out_v_q || pixel_out.ready;
	assign stall    = emit && pend_v_q && !out_free;
	assign scan_end = ((i_q == last_col) && (r_q == 3'd7)) ||
	                  (emit && (n_q == 6'(MAX_PIXELS - 1)));
	assign out_load = ((state_q == ST_SCAN) && emit && pend_v_q && !stall) ||
	                  ((state_q == ST_FLUSH) && pend_v_q && out_free);

	always_comb begin
		cand.pixel_addr   = row_addr_q + {{11{px[18]}}, px, 2'b00};
		cand.pixel_x      = px[11:0];
		cand.pixel_y      = py[11:0];
		cand.pixel_colour = bit_set ? fore_q : back_q;
		cand.last_pixel   = 1'b0;
		pend_last            = pend_q;
		pend_last.last_pixel = 1'b1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
			pitch_q  <= ROW_PITCH_RST;
			base_q   <= FRAME_BASE_RST;
			fore_q   <= FORE_COLOUR_RST;
			back_q   <= BACK_COLOUR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[12:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[12:0];
				REG_ROW_PITCH:    pitch_q  <= cfg_data[15:0];
				REG_FRAME_BASE:   base_q   <= cfg_data;
				REG_FORE_COLOUR:  fore_q   <= cfg_data;
				REG_BACK_COLOUR:  back_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, cursor and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= 3'd0;
			cursor_q <= 18'd0;
			row_q    <= 16'sd0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			r_q      <= 3'd0;
			i_q      <= 5'd0;
			n_q      <= 6'd0;
		end else begin
			if (out_v_q && pixel_out.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cursor_q <= cx_new +
						            ((in_item.char_code == TAB_CODE) ? TAB_ADV : CELL_ADV);
						row_q    <= ty_new;
						step_q   <= 3'd0;
						state_q  <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (step_q == 3'd5) begin
						r_q     <= 3'd0;
						i_q     <= 5'd0;
						n_q     <= 6'd0;
						state_q <= ST_SCAN;
					end
					step_q <= step_q + 3'd1;
				end
				ST_SCAN: begin
					if (!stall) begin
						if (emit) begin
							n_q      <= n_q + 6'd1;
							pend_v_q <= 1'b1;
							if (pend_v_q) begin
								out_v_q <= 1'b1;
							end
						end
						if (i_q == last_col) begin
							i_q <= 5'd0;
							r_q <= r_q + 3'd1;
						end else begin
							i_q <= i_q + 5'd1;
						end
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					code_q <= in_item.char_code;
					tab_q  <= (in_item.char_code == TAB_CODE);
					k_q    <= {1'b0, in_item.char_code, 2'b00} + {2'b00, in_item.char_code, 1'b0};
					cx_q   <= cx_new;
					ty_q   <= ty_new;
				end
			end
			ST_SETUP: begin
				glyph_q[{step_q, 3'b000} +: 8] <= glyph_ok ? font_byte(k_q) : 8'd0;
				k_q <= k_q + 11'd1;
				if (step_q == 3'd0) begin
					prod_q <= prod_full[31:0];
				end
				if (step_q == 3'd1) begin
					row_addr_q <= base_q + prod_q;
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					if (emit) begin
						pend_q <= cand;
						if (pend_v_q) begin
							out_q <= pend_q;
						end
					end
					if (i_q == last_col) begin
						row_addr_q <= row_addr_q + {16'd0, pitch_q};
					end
				end
			end
			ST_FLUSH: begin
				if (pend_v_q && out_free) begin
					out_q <= pend_last;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/gtr_checker.sv
// Port-level assertions for the 6x8 glyph text renderer, bound to the top level.
module gtr_checker
	import gtr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input pixel_item_t out_payload
);

	// a stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("pixel item changed while stalled");

	// glyph load keeps the input closed
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("char item taken right after another");

	a_busy_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##6 !in_ready)
		else $error("input reopened during glyph load");

endmodule

bind glyph_text_renderer_6x8_core gtr_checker u_gtr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (char_in.valid),
	.in_ready   (char_in.ready),
	.out_valid  (pixel_out.valid),
	.out_ready  (pixel_out.ready),
	.out_payload(pixel_out.payload)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the 6x8 glyph text renderer: directed and random text, pixel compare.
module testbench;
	import gtr_pkg::*;

	localparam logic [31:0] GLYPH_ROM [384] = '{
		32'h00000000, 32'h3E000000, 32'h3E455145, 32'h6F6B3E00, 32'h1C003E6B,
		32'h1C3E7C3E, 32'h7E3C1800, 32'h3000183C, 32'h30367F36, 32'h7E5C1800,
		32'h0000185C, 32'h00001818, 32'hE7E7FFFF, 32'h0000FFFF, 32'h00000000,
		32'hDBDBC3FF, 32'h3000FFC3, 32'h0E364A48, 32'h79290600, 32'h60000629,
		32'h04023F70, 32'h0A7E6000, 32'h2A003F35, 32'h2A1C361C, 32'h3E7F0000,
		32'h0800081C, 32'h007F3E1C, 32'h7F361400, 32'h00001436, 32'h005F005F,
		32'h7F090600, 32'h22007F01, 32'h2259554D, 32'h60606000, 32'h14000060,
		32'h14B6FFB6, 32'h7F060400, 32'h10000406, 32'h10307F30, 32'h3E080800,
		32'h0800081C, 32'h08083E1C, 32'h40407800, 32'h08004040, 32'h083E083E,
		32'h3F3C3000, 32'h0300303C, 32'h030F3F0F, 32'h00000000, 32'h00000000,
		32'h00065F06, 32'h00030700, 32'h24000307, 32'h247E247E, 32'h6A2B2400,
		32'h63000012, 32'h63640813, 32'h56493600, 32'h00005020, 32'h00000307,
		32'h413E0000, 32'h00000000, 32'h00003E41, 32'h1C3E0800, 32'h0800083E,
		32'h08083E08, 32'h60E00000, 32'h08000000, 32'h08080808, 32'h60600000,
		32'h20000000, 32'h02040810, 32'h49513E00, 32'h00003E45, 32'h00407F42,
		32'h49516200, 32'h22004649, 32'h36494949, 32'h12141800, 32'h2F00107F,
		32'h31494949, 32'h494A3C00, 32'h01003049, 32'h03050971, 32'h49493600,
		32'h06003649, 32'h1E294949, 32'h6C6C0000, 32'h00000000, 32'h00006CEC,
		32'h22140800, 32'h24000041, 32'h24242424, 32'h22410000, 32'h02000814,
		32'h06095901, 32'h5D413E00, 32'h7E001E55, 32'h7E111111, 32'h49497F00,
		32'h3E003649, 32'h22414141, 32'h41417F00, 32'h7F003E41, 32'h41494949,
		32'h09097F00, 32'h3E000109, 32'h7A494941, 32'h08087F00, 32'h00007F08,
		32'h00417F41, 32'h40403000, 32'h7F003F40, 32'h41221408, 32'h40407F00,
		32'h7F004040, 32'h7F020402, 32'h04027F00, 32'h3E007F08, 32'h3E414141,
		32'h09097F00, 32'h3E000609, 32'h5E215141, 32'h09097F00, 32'h26006619,
		32'h32494949, 32'h7F010100, 32'h3F000101, 32'h3F404040, 32'h40201F00,
		32'h3F001F20, 32'h3F403C40, 32'h08146300, 32'h07006314, 32'h07087008,
		32'h45497100, 32'h00000043, 32'h0041417F, 32'h08040200, 32'h00002010,
		32'h007F4141, 32'h01020400, 32'h80800402, 32'h80808080, 32'h07030000,
		32'h20000000, 32'h78545454, 32'h44447F00, 32'h38003844, 32'h28444444,
		32'h44443800, 32'h38007F44, 32'h08545454, 32'h097E0800, 32'h18000009,
		32'h7CA4A4A4, 32'h04047F00, 32'h00000078, 32'h00407D00, 32'h84804000,
		32'h7F00007D, 32'h00442810, 32'h7F000000, 32'h7C000040, 32'h78041804,
		32'h04047C00, 32'h38000078, 32'h38444444, 32'h4444FC00, 32'h38003844,
		32'hFC444444, 32'h44784400, 32'h08000804, 32'h20545454, 32'h443E0400,
		32'h3C000024, 32'h007C2040, 32'h40201C00, 32'h3C001C20, 32'h3C603060,
		32'h10106C00, 32'h9C00006C, 32'h003C60A0, 32'h54546400, 32'h0800004C,
		32'h0041413E, 32'h77000000, 32'h00000000, 32'h083E4141, 32'h02010200,
		32'h3C000001, 32'h3C262326, 32'hE1A11E00, 32'h3D001221, 32'h007D2040,
		32'h54543800, 32'h20000955, 32'h78555555, 32'h54552000, 32'h20007855,
		32'h78545555, 32'h55572000, 32'h1C007857, 32'h1422E2A2, 32'h55553800,
		32'h38000855, 32'h08555455, 32'h55553800, 32'h00000854, 32'h00417C01,
		32'h79020000, 32'h00000042, 32'h00407C01, 32'h24297000, 32'h78007029,
		32'h782F252F, 32'h54547C00, 32'h34004555, 32'h58547C54, 32'h7F097E00,
		32'h38004949, 32'h00394545, 32'h44453800, 32'h39000039, 32'h00384445,
		32'h21413C00, 32'h3D00007D, 32'h007C2041, 32'h60A19C00, 32'h3D00003D,
		32'h003D4242, 32'h40413C00, 32'h1800003D, 32'h00246624, 32'h493E4800,
		32'h29006249, 32'h292A7C2A, 32'h16097F00, 32'h40001078, 32'h02097E88,
		32'h55542000, 32'h00007855, 32'h00417D00, 32'h45443800, 32'h3C000039,
		32'h007D2140, 32'h0A097A00, 32'h7A000071, 32'h00792211, 32'h55550800,
		32'h4E005E55, 32'h004E5151, 32'h4D483000, 32'h3C002040, 32'h04040404,
		32'h04040404, 32'h17001C04, 32'h506A4C08, 32'h34081700, 32'h0000782A,
		32'h00307D30, 32'h00140800, 32'h14001408, 32'h08140008, 32'h11441144,
		32'h55AA1144, 32'h55AA55AA, 32'hEEBBEEBB, 32'h0000EEBB, 32'h0000FF00,
		32'hFF080808, 32'h0A0A0000, 32'h0000FF0A, 32'hFF00FF08, 32'hF8080000,
		32'h0000F808, 32'hFE0A0A0A, 32'hFB0A0000, 32'h0000FF00, 32'hFF00FF00,
		32'hFA0A0000, 32'h0000FE02, 32'h0F080B0A, 32'h0F080000, 32'h00000F08,
		32'h0F0A0A0A, 32'h08080000, 32'h0000F808, 32'h0F000000, 32'h08080808,
		32'h08080F08, 32'hF8080808, 32'h00000808, 32'h0808FF00, 32'h08080808,
		32'h08080808, 32'h0808FF08, 32'hFF000000, 32'hFF000A0A, 32'h0808FF00,
		32'h0B080F00, 32'hFE000A0A, 32'h0A0AFA02, 32'h0B080B0A, 32'hFA0A0A0A,
		32'h0A0AFA02, 32'hFB00FF00, 32'h0A0A0A0A, 32'h0A0A0A0A, 32'hFB00FB0A,
		32'h0A0A0A0A, 32'h0A0A0B0A, 32'h0F080F08, 32'h0A0A0808, 32'h0A0AFA0A,
		32'hF808F808, 32'h0F000808, 32'h08080F08, 32'h0F000000, 32'h00000A0A,
		32'h0A0AFE00, 32'hF808F800, 32'hFF080808, 32'h0808FF00, 32'hFB0A0A0A,
		32'h08080A0A, 32'h00000F08, 32'hF8000000, 32'hFFFF0808, 32'hFFFFFFFF,
		32'hF0F0F0F0, 32'hFFFFF0F0, 32'h000000FF, 32'hFF000000, 32'h0F0FFFFF,
		32'h0F0F0F0F, 32'h24241800, 32'hFE002418, 32'h00344A4A, 32'h01017F00,
		32'h02000003, 32'h027E027E, 32'h49556300, 32'h18000063, 32'h041C2424,
		32'h2020FC00, 32'h0800001C, 32'h00047804, 32'h77550800, 32'h3E000855,
		32'h003E4949, 32'h02724C00, 32'h22004C72, 32'h00305955, 32'h18241800,
		32'h18001824, 32'h18247E24, 32'h2A2A1C00, 32'h3C00002A, 32'h003C0202,
		32'h2A2A2A00, 32'h0000002A, 32'h00242E24, 32'h4A4A5100, 32'h44000044,
		32'h00514A4A, 32'hFC000000, 32'h20000402, 32'h00003F40, 32'h2A080800,
		32'h24000808, 32'h00122412, 32'h09090600, 32'h00000006, 32'h00001818,
		32'h00080000, 32'h30000000, 32'h02023E40, 32'h010E0100, 32'h0900000E,
		32'h00000A0D, 32'h3C3C3C00, 32'h0000003C, 32'h00000000
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	gtr_stream_if #(.payload_t(char_item_t))  char_if ();
	gtr_stream_if #(.payload_t(pixel_item_t)) pix_if ();

	glyph_text_renderer_6x8_core #(.CHAR_COUNT(CHAR_COUNT_DEF)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.char_in(char_if),
		.pixel_out(pix_if)
	);

	// predicted block state and registers
	logic [12:0] fb_width, fb_height;
	logic [15:0] fb_pitch;
	logic [31:0] fb_base, ink, paper;
	logic [17:0] pen_x;
	logic [15:0] pen_y;

	char_item_t  text_chars [$];
	pixel_item_t expected_pixels [$];
	pixel_item_t got, want;
	int chars_queued = 0;
	int chars_taken = 0;
	int mismatches = 0;
	int src_odds = 0, snk_odds = 0;
	int src_gap, snk_gap;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void render_char(input char_item_t item);
		logic [7:0]  cols [6];
		pixel_item_t held;
		logic        have_held, is_tab, opaque, lit;
		int          cx, ty, px, py, r, c, k, span, n;
		is_tab = item.char_code == TAB_CODE;
		opaque = !paper[31];
		if (item.start_text) begin
			pen_x = {{2{item.origin_x[15]}}, item.origin_x};
			pen_y = item.origin_y;
		end
		cx = $signed(pen_x);
		ty = $signed(pen_y);
		for (c = 0; c < 6; c++) begin
			k = int'(item.char_code) * 6 + c;
			cols[c] = (int'(item.char_code) < CHAR_COUNT_DEF) ?
				GLYPH_ROM[k / 4][8 * (k % 4) +: 8] : 8'h00;
		end
		span = (is_tab && opaque) ? int'(TAB_COLS) : int'(CELL_COLS);
		held = '0;
		have_held = 1'b0;
		n = 0;
		for (r = 0; r < 8; r++) begin
			py = ty + r;
			if (py >= 0 && py < int'(fb_height)) begin
				for (c = 0; c < span; c++) begin
					px = cx + c;
					lit = (c < 6) ? cols[c][r] : 1'b0;
					if (px >= 0 && px < int'(fb_width) && (lit || opaque) && n < MAX_PIXELS) begin
						if (have_held)
							expected_pixels.push_back(held);
						held.pixel_addr   = fb_base + fb_pitch * py + 4 * px;
						held.pixel_x      = 12'(px);
						held.pixel_y      = 12'(py);
						held.pixel_colour = lit ? ink : paper;
						held.last_pixel   = 1'b0;
						have_held = 1'b1;
						n++;
					end
				end
			end
		end
		if (have_held) begin
			held.last_pixel = 1'b1;
			expected_pixels.push_back(held);
		end
		pen_x = pen_x + (is_tab ? TAB_ADV : CELL_ADV);
	endfunction

	// character source
	always @(posedge clk) begin
		if (!arst_n) begin
			char_if.valid <= 1'b0;
			src_gap = 0;
			pen_x = '0;
			pen_y = '0;
		end else begin
			if (char_if.valid && char_if.ready) begin
				chars_taken++;
				render_char(char_if.payload);
			end
			if (!char_if.valid || char_if.ready) begin
				if (src_gap != 0) begin
					char_if.valid <= 1'b0;
					src_gap--;
				end else if (text_chars.size() == 0) begin
					char_if.valid <= 1'b0;
				end else if ($urandom_range(15, 0) < src_odds) begin
					char_if.valid <= 1'b0;
					src_gap = $urandom_range(15, 0);
				end else begin
					char_if.payload <= text_chars.pop_front();
					char_if.valid <= 1'b1;
				end
			end
		end
	end

	// pixel sink and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_if.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (pix_if.valid && pix_if.ready) begin
				got = pix_if.payload;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel: addr %h x %0d y %0d colour %h last %b",
							got.pixel_addr, got.pixel_x, got.pixel_y, got.pixel_colour,
							got.last_pixel);
				end else begin
					want = expected_pixels.pop_front();
					if (got.pixel_addr !== want.pixel_addr || got.pixel_x !== want.pixel_x ||
							got.pixel_y !== want.pixel_y ||
							got.pixel_colour !== want.pixel_colour ||
							got.last_pixel !== want.last_pixel) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %h %0d %0d %h %b, got %h %0d %0d %h %b",
								want.pixel_addr, want.pixel_x, want.pixel_y,
								want.pixel_colour, want.last_pixel,
								got.pixel_addr, got.pixel_x, got.pixel_y,
								got.pixel_colour, got.last_pixel);
					end
				end
			end
			if (snk_gap != 0) begin
				pix_if.ready <= 1'b0;
				snk_gap--;
			end else if ($urandom_range(15, 0) < snk_odds) begin
				pix_if.ready <= 1'b0;
				snk_gap = $urandom_range(15, 0);
			end else begin
				pix_if.ready <= 1'b1;
			end
		end
	end

	task automatic queue_char(input logic [7:0] code, input logic start,
			input logic [15:0] ox, input logic [15:0] oy);
		char_item_t item;
		item.char_code  = code;
		item.start_text = start;
		item.origin_x   = ox;
		item.origin_y   = oy;
		text_chars.push_back(item);
		chars_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	task automatic program_frame(input logic [31:0] w, input logic [31:0] h,
			input logic [31:0] p, input logic [31:0] base,
			input logic [31:0] fg, input logic [31:0] bg);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_ROW_PITCH, p);
		write_reg(REG_FRAME_BASE, base);
		write_reg(REG_FORE_COLOUR, fg);
		write_reg(REG_BACK_COLOUR, bg);
		@(posedge clk);
		cfg_we <= 1'b0;
		fb_width  = w[12:0];
		fb_height = h[12:0];
		fb_pitch  = p[15:0];
		fb_base   = base;
		ink       = fg;
		paper     = bg;
	endtask

	// items that render nothing still keep the block busy through setup and scan
	task automatic wait_quiet();
		while (chars_taken != chars_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic int rand_extent();
		case ($urandom_range(3, 0))
			0: return $urandom_range(8191, 0);
			1: return $urandom_range(40, 0);
			default: return $urandom_range(1200, 100);
		endcase
	endfunction

	initial begin
		int w, h, ox, oy, n, len, i, ph;
		logic [7:0] code;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_data        = '0;
		arst_n          = 1'b0;
		fb_width  = 13'd640;
		fb_height = 13'd480;
		fb_pitch  = 16'd2560;
		fb_base   = 32'h0;
		ink       = 32'hFFFF_FFFF;
		paper     = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, transparent background
		src_odds = 3;
		snk_odds = 3;
		queue_char(8'h41, 1'b1, 16'h0000, 16'h0000);
		queue_char(8'h00, 1'b0, 16'hFFFF, 16'hFFFF);
		queue_char(8'hFF, 1'b0, 16'h0000, 16'h0000);
		queue_char(TAB_CODE, 1'b0, 16'h5A5A, 16'hA5A5);
		queue_char(8'h7F, 1'b0, 16'h0000, 16'h0000);
		wait_quiet();

		// widest frame, opaque zero background, address wrap
		program_frame(32'd8191, 32'd8191, 32'd65535, 32'hFFFF_FFF0, 32'h0, 32'h0);
		queue_char(8'hDB, 1'b1, 16'd4090, 16'd4090);
		queue_char(TAB_CODE, 1'b0, 16'h0000, 16'h0000);
		queue_char(8'h41, 1'b1, 16'hFFFD, 16'hFFFB);
		queue_char(8'h41, 1'b1, 16'h8000, 16'h8000);
		queue_char(8'h42, 1'b1, 16'h7FFF, 16'h7FFF);
		queue_char(8'h42, 1'b1, 16'hFFFA, 16'h0000);
		queue_char(8'h43, 1'b0, 16'h0000, 16'h0000);
		queue_char(TAB_CODE, 1'b1, 16'hFFF6, 16'h0002);
		wait_quiet();

		// empty frame
		program_frame(32'd0, 32'd0, 32'd2560, 32'h0, 32'hFFFF_FFFF, 32'h0);
		queue_char(8'h41, 1'b1, 16'h0000, 16'h0000);
		queue_char(TAB_CODE, 1'b0, 16'h0000, 16'h0000);
		wait_quiet();

		// tiny frame, zero pitch, largest opaque background
		program_frame(32'd17, 32'd5, 32'd0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		queue_char(TAB_CODE, 1'b1, 16'd12, 16'd1);
		queue_char(8'h57, 1'b0, 16'h0000, 16'h0000);
		wait_quiet();

		program_frame(32'd4096, 32'd4096, 32'd1, 32'h0000_1000, 32'h8000_0001,
			32'h8000_0000);
		queue_char(8'hFF, 1'b1, 16'd4093, 16'd4093);
		queue_char(TAB_CODE, 1'b0, 16'h0000, 16'h0000);
		queue_char(8'h80, 1'b1, 16'd100, 16'd200);
		wait_quiet();

		for (ph = 0; ph < 5; ph++) begin
			w = rand_extent();
			h = rand_extent();
			program_frame(w, h, $urandom_range(65535, 0), $urandom, $urandom, $urandom);
			src_odds = (ph == 4) ? 0 : $urandom_range(4, 0);
			snk_odds = (ph == 4) ? 0 : $urandom_range(4, 0);
			n = 0;
			while (n < 16) begin
				if ($urandom_range(4, 0) == 0) begin
					queue_char(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
					n++;
				end else begin
					ox = int'($urandom_range(w + 16, 0)) - 12;
					oy = int'($urandom_range(h + 16, 0)) - 12;
					code = ($urandom_range(5, 0) == 0) ? TAB_CODE : 8'($urandom);
					queue_char(code, 1'b1, 16'(ox), 16'(oy));
					len = $urandom_range(7, 2);
					for (i = 0; i < len; i++) begin
						code = ($urandom_range(5, 0) == 0) ? TAB_CODE : 8'($urandom);
						queue_char(code, 1'b0, 16'($urandom), 16'($urandom));
					end
					n += len + 1;
				end
			end
			wait_quiet();
		end

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
